>>> src/integer_to_english_words_assert.svh
// Assertion macros used by the integer-to-words back end.
`ifndef INTEGER_TO_ENGLISH_WORDS_ASSERT_SVH
`define INTEGER_TO_ENGLISH_WORDS_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ITEW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ITEW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/itew_pkg.sv
// Shared types and constants of the integer-to-words block.
`default_nettype none
package itew_pkg;

    localparam int VALUE_W   = 31;
    localparam int WORD_W    = 5;
    localparam int DIGITS    = 10;
    localparam int BIN_W     = 32;
    localparam int CONV_STEPS = BIN_W / 2;
    localparam int STEP_W    = $clog2(CONV_STEPS);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef logic [3:0] digit_t;
    typedef digit_t [DIGITS-1:0] bcd_t;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t W_ZERO      = 5'd0;
    localparam word_t W_TEN       = 5'd10;
    localparam word_t W_TENS_BASE = 5'd18;
    localparam word_t W_HUNDRED   = 5'd28;
    localparam word_t W_THOUSAND  = 5'd29;
    localparam word_t W_MILLION   = 5'd30;
    localparam word_t W_BILLION   = 5'd31;

    typedef enum logic [1:0] {
        GRP_BILLION  = 2'd0,
        GRP_MILLION  = 2'd1,
        GRP_THOUSAND = 2'd2,
        GRP_UNITS    = 2'd3
    } group_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_HOLD
    } front_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ZERO,
        PH_HUND,
        PH_HWORD,
        PH_TENS,
        PH_ONES,
        PH_SCALE
    } phase_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

>>> src/integer_to_english_words.sv
// The front end converts two bits per cycle of binary-to-decimal conversion and takes a new
// value only after its digit set has been handed to the queue. The back end walks one group
// step at a time, and only while the output register is free or being taken; zero groups are
// skipped, and tokens leave at most one per cycle.
// Reset: rst_n is asynchronous and active low; it empties the queue and the output register.
`default_nettype none
module integer_to_english_words (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [itew_pkg::VALUE_W-1:0] value,
    output logic                              empty,
    input  wire logic                         pop,
    output itew_pkg::word_t                   word_code,
    output logic                              last_word
);
    import itew_pkg::*;

    // The front end converts each accepted value into ten decimal digits with a
    // double-dabble shifter. A finished digit set is transferred into a short
    // queue, so the front end can take a new value while the back end is still
    // spelling out the previous one.
    q_status_t  q_status;
    logic       q_push;
    logic       q_pop;
    bcd_t       q_wdata;
    bcd_t       q_rdata;

    itew_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .value    (value),
        .full     (full),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    itew_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .status    (q_status)
    );

    // The back end walks the billion, million, thousand and unit groups. Each
    // step may produce one token into the output register, which holds it
    // until the consumer takes the transfer. Zero groups are skipped, and the
    // final token carries last_word.
    itew_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .word_code (word_code),
        .last_word (last_word)
    );

endmodule
`default_nettype wire

>>> src/itew_front.sv
// Front end: converts the binary value to decimal digits, two bits per cycle.
`default_nettype none
module itew_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [itew_pkg::VALUE_W-1:0] value,
    output logic                   full,
    input  itew_pkg::q_status_t    q_status,
    output logic                   q_push,
    output itew_pkg::bcd_t         q_data
);
    import itew_pkg::*;

    front_state_t           state_reg, state_next;
    logic [BIN_W-1:0]       bin_reg, bin_next;
    bcd_t                   bcd_reg, bcd_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    bcd_t                   adj1, adj2;
    logic [4*DIGITS-1:0]    flat1, flat2, shift1, shift2;

    // Add three to every digit of five or more before the next shift.
    function automatic bcd_t dabble_adjust(input bcd_t b);
        bcd_t r;
        for (int i = 0; i < DIGITS; i++) begin
            r[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
        end
        return r;
    endfunction

    always_comb
    begin
        adj1   = dabble_adjust(bcd_reg);
        flat1  = adj1;
        shift1 = {flat1[4*DIGITS-2:0], bin_reg[BIN_W-1]};
        adj2   = dabble_adjust(bcd_t'(shift1));
        flat2  = adj2;
        shift2 = {flat2[4*DIGITS-2:0], bin_reg[BIN_W-2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        full       = 1'b1;
        q_push     = 1'b0;
        q_data     = bcd_reg;
        case (state_reg)
            F_IDLE:
            begin
                full = 1'b0;
                if (push)
                begin
                    bin_next   = {1'b0, value};
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                bcd_next  = bcd_t'(shift2);
                bin_next  = {bin_reg[BIN_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CONV_STEPS - 1))
                begin
                    state_next = F_HOLD;
                end
            end
            F_HOLD:
            begin
                q_push = !q_status.full;
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/itew_queue.sv
// Two-entry queue of decimal digit sets between front and back ends.
`default_nettype none
module itew_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  itew_pkg::bcd_t       push_data,
    input  wire logic            pop,
    output itew_pkg::bcd_t       pop_data,
    output itew_pkg::q_status_t  status
);
    import itew_pkg::*;

    bcd_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    logic do_push, do_pop;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> src/itew_back.sv
// Back end: walks the digit groups; at most one word token per unstalled cycle.
`default_nettype none
`include "integer_to_english_words_assert.svh"
module itew_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  itew_pkg::q_status_t  q_status,
    input  itew_pkg::bcd_t       q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output itew_pkg::word_t      word_code,
    output logic                 last_word
);
    import itew_pkg::*;

    phase_t      phase_reg, phase_next;
    group_idx_t  grp_reg, grp_next;
    bcd_t        dig_reg, dig_next;
    logic        out_valid_reg, out_valid_next;
    word_t       word_reg, word_next;
    logic        last_reg, last_next;

    digit_t      h, t, u;
    logic [3:0]  grp_nz;
    logic        lower_nz;
    logic        is_units;
    logic        advance;
    logic        emit;
    word_t       emit_word;
    logic        emit_last;

    // The billions group holds only the top decimal digit.
    always_comb
    begin
        grp_nz[GRP_BILLION]  = (dig_reg[9] != '0);
        grp_nz[GRP_MILLION]  = ({dig_reg[8], dig_reg[7], dig_reg[6]} != '0);
        grp_nz[GRP_THOUSAND] = ({dig_reg[5], dig_reg[4], dig_reg[3]} != '0);
        grp_nz[GRP_UNITS]    = ({dig_reg[2], dig_reg[1], dig_reg[0]} != '0);
        case (grp_reg)
            GRP_BILLION:
            begin
                h = '0;         t = '0;         u = dig_reg[9];
                lower_nz = grp_nz[GRP_MILLION] || grp_nz[GRP_THOUSAND] || grp_nz[GRP_UNITS];
            end
            GRP_MILLION:
            begin
                h = dig_reg[8]; t = dig_reg[7]; u = dig_reg[6];
                lower_nz = grp_nz[GRP_THOUSAND] || grp_nz[GRP_UNITS];
            end
            GRP_THOUSAND:
            begin
                h = dig_reg[5]; t = dig_reg[4]; u = dig_reg[3];
                lower_nz = grp_nz[GRP_UNITS];
            end
            default:
            begin
                h = dig_reg[2]; t = dig_reg[1]; u = dig_reg[0];
                lower_nz = 1'b0;
            end
        endcase
        is_units = (grp_reg == GRP_UNITS);
    end

    assign empty     = !out_valid_reg;
    assign word_code = word_reg;
    assign last_word = last_reg;
    assign q_pop     = (phase_reg == PH_IDLE) && !q_status.empty;
    assign advance   = (phase_reg != PH_IDLE) && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            grp_reg       <= GRP_BILLION;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        grp_next   = grp_reg;
        dig_next   = dig_reg;
        emit       = 1'b0;
        emit_word  = W_ZERO;
        emit_last  = 1'b0;
        if (q_pop)
        begin
            dig_next   = q_data;
            grp_next   = GRP_BILLION;
            phase_next = (q_data == '0) ? PH_ZERO : PH_HUND;
        end
        else if (advance)
        begin
            case (phase_reg)
                PH_ZERO:
                begin
                    emit       = 1'b1;
                    emit_word  = W_ZERO;
                    emit_last  = 1'b1;
                    phase_next = PH_IDLE;
                end
                PH_HUND:
                begin
                    if (!grp_nz[grp_reg])
                    begin
                        // An all-zero group is skipped along with its scale word.
                        if (is_units)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            grp_next = group_idx_t'(grp_reg + 2'd1);
                        end
                    end
                    else if (h != '0)
                    begin
                        emit       = 1'b1;
                        emit_word  = {1'b0, h};
                        phase_next = PH_HWORD;
                    end
                    else
                    begin
                        phase_next = PH_TENS;
                    end
                end
                PH_HWORD:
                begin
                    emit       = 1'b1;
                    emit_word  = W_HUNDRED;
                    emit_last  = is_units && (t == '0) && (u == '0);
                    phase_next = PH_TENS;
                end
                PH_TENS:
                begin
                    if (t >= 4'd2)
                    begin
                        emit       = 1'b1;
                        emit_word  = W_TENS_BASE + {1'b0, t};
                        emit_last  = is_units && (u == '0);
                        phase_next = PH_ONES;
                    end
                    else if (t == 4'd1)
                    begin
                        // Ten through nineteen are single words.
                        emit       = 1'b1;
                        emit_word  = W_TEN + {1'b0, u};
                        emit_last  = is_units;
                        phase_next = PH_SCALE;
                    end
                    else
                    begin
                        phase_next = PH_ONES;
                    end
                end
                PH_ONES:
                begin
                    if (u != '0)
                    begin
                        emit      = 1'b1;
                        emit_word = {1'b0, u};
                        emit_last = is_units;
                    end
                    phase_next = PH_SCALE;
                end
                PH_SCALE:
                begin
                    if (is_units)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_last = !lower_nz;
                        case (grp_reg)
                            GRP_BILLION:  emit_word = W_BILLION;
                            GRP_MILLION:  emit_word = W_MILLION;
                            default:      emit_word = W_THOUSAND;
                        endcase
                        grp_next   = group_idx_t'(grp_reg + 2'd1);
                        phase_next = PH_HUND;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
            word_next      = emit_word;
            last_next      = emit_last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    `ITEW_ASSERT_NEXT(a_stall_hold, out_valid_reg && !pop, out_valid_reg && $stable(word_reg) && $stable(last_reg), "stalled token changed")
    `ITEW_ASSERT_NEXT(a_idle_quiet, phase_reg == PH_IDLE && !out_valid_reg, !out_valid_reg, "token appeared while idle")
    `ITEW_ASSERT_NOW(a_load_only_busy, q_pop, phase_reg == PH_IDLE && !advance, "load while sequencing")

endmodule
`default_nettype wire
